// ----- src/tfd_pkg.sv -----
package tfd_pkg;

    localparam int AXIS_W  = 16;
    localparam int REF_W   = 20;
    localparam int MAG_W   = 16;
    localparam int CNT_W   = 4;
    localparam int SQ_W    = 32;
    localparam int SSQ_W   = 40;
    localparam int TERM_W  = 36;
    localparam int DOT_W   = 38;
    localparam int ROOT_W  = 20;
    localparam int REM_W   = 21;
    localparam int P1_W    = 32;
    localparam int RHS_W   = 52;
    localparam int LHS_W   = 54;
    localparam int STEP_W  = 5;

    localparam int MUL_STEPS  = 20;
    localparam int SQRT_STEPS = 20;
    localparam int RHS1_STEPS = 16;
    localparam int RHS2_STEPS = 20;

    localparam int MAX_CALIB_SAMPLES = 15;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0]      RST_MAG_LOW  = 16'd11469;
    localparam logic [15:0]      RST_MAG_HIGH = 16'd21299;
    localparam logic [CNT_W-1:0] RST_SAMPLES  = 4'd10;
    localparam logic [15:0]      RST_COS      = 16'd23167;
    localparam logic [CNT_W-1:0] RST_CONFIRM  = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAG_LOW  = 3'd0,
        REG_MAG_HIGH = 3'd1,
        REG_SAMPLES  = 3'd2,
        REG_COS      = 3'd3,
        REG_CONFIRM  = 3'd4
    } tfd_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SQRT,
        ST_DECIDE,
        ST_RHS1,
        ST_RHS2,
        ST_CMP,
        ST_OUT
    } tfd_state_t;

endpackage

// ----- src/tfd_if.sv -----
interface tfd_sample_if;
    import tfd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  output ready);
endinterface

interface tfd_result_if;
    import tfd_pkg::*;
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] accel_magnitude;
    logic [MAG_W-1:0] gyro_magnitude;
    logic             fall_detected;
    logic             calibrated;
    modport source (output valid, accel_magnitude, gyro_magnitude, fall_detected, calibrated,
                    input ready);
    modport sink (input valid, accel_magnitude, gyro_magnitude, fall_detected, calibrated,
                  output ready);
endinterface

interface tfd_cfg_if;
    import tfd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/tilt_fall_detector_core.sv -----
// Tilt and fall detector.
// sample: one transfer carries three accelerometer and three gyro axes.
// result: one transfer per sample with both floor-sqrt magnitudes, the fall
//   flag and the calibrated flag.
// cfg: register writes, taken every cycle; write only while idle.
// Each sample runs through bit-serial shift-add multipliers and
// digit-by-digit square roots, two radicand bits a cycle.
// While calibrating, an item goes from the square roots to the result load;
// after calibration the tilt product cos*|a|*|S| adds two more serial
// multiplies and a compare. The sample channel is ready again in the
// cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, the
// finished item waits in the last state until that register is free.
// Reset clears the gravity reference, counters, fall flag and restores the
// register defaults; the first samples after reset calibrate.
module tilt_fall_detector_core (
    input  logic         clk,
    input  logic         rst_n,
    tfd_sample_if.sink   sample,
    tfd_result_if.source result,
    tfd_cfg_if.sink      cfg
);
    import tfd_pkg::*;

    tfd_state_t state_reg, state_next;

    logic [15:0]      low_reg, low_next, high_reg, high_next, cos_reg, cos_next;
    logic [CNT_W-1:0] samples_reg, samples_next, confirm_reg, confirm_next;

    logic signed [REF_W-1:0] ref_reg [3];
    logic signed [REF_W-1:0] ref_next [3];
    logic [CNT_W-1:0] taken_reg, taken_next, run_reg, run_next;
    logic             fall_reg, fall_next;

    logic signed [AXIS_W-1:0] acc_reg [3];
    logic signed [AXIS_W-1:0] acc_next [3];
    logic [AXIS_W-1:0] amq_reg [3];
    logic [AXIS_W-1:0] amq_next [3];
    logic [AXIS_W-1:0] gmq_reg [3];
    logic [AXIS_W-1:0] gmq_next [3];
    logic [REF_W-1:0]  smq_reg [3];
    logic [REF_W-1:0]  smq_next [3];
    logic [SQ_W-1:0]   amc_reg [3];
    logic [SQ_W-1:0]   amc_next [3];
    logic [SQ_W-1:0]   gmc_reg [3];
    logic [SQ_W-1:0]   gmc_next [3];
    logic [SSQ_W-1:0]  smc_reg [3];
    logic [SSQ_W-1:0]  smc_next [3];
    logic signed [TERM_W-1:0] dmc_reg [3];
    logic signed [TERM_W-1:0] dmc_next [3];
    logic [SQ_W-1:0]   asq_reg [3];
    logic [SQ_W-1:0]   asq_next [3];
    logic [SQ_W-1:0]   gsq_reg [3];
    logic [SQ_W-1:0]   gsq_next [3];
    logic [SSQ_W-1:0]  ssq_reg [3];
    logic [SSQ_W-1:0]  ssq_next [3];
    logic signed [TERM_W-1:0] term_reg [3];
    logic signed [TERM_W-1:0] term_next [3];

    logic [SSQ_W-1:0]  rad_reg [3];
    logic [SSQ_W-1:0]  rad_next [3];
    logic [REM_W-1:0]  rem_reg [3];
    logic [REM_W-1:0]  rem_next [3];
    logic [ROOT_W-1:0] root_reg [3];
    logic [ROOT_W-1:0] root_next [3];
    logic signed [DOT_W-1:0] dsum_reg, dsum_next;

    logic [15:0]      p1q_reg, p1q_next;
    logic [P1_W-1:0]  p1mc_reg, p1mc_next, p1_reg, p1_next;
    logic [ROOT_W-1:0] p2q_reg, p2q_next;
    logic [RHS_W-1:0] p2mc_reg, p2mc_next, rhs_reg, rhs_next;

    logic [STEP_W-1:0] cnt_reg, cnt_next;

    logic             out_valid_reg, out_valid_next, fall_out_reg, fall_out_next;
    logic             cal_out_reg, cal_out_next;
    logic [MAG_W-1:0] amag_out_reg, amag_out_next, gmag_out_reg, gmag_out_next;

    logic signed [AXIS_W-1:0] a_in [3];
    logic signed [AXIS_W-1:0] g_in [3];
    logic [CNT_W-1:0] target;
    logic             calibrating;
    logic [MAG_W-1:0] amag, am;
    logic [ROOT_W-1:0] smag;
    logic signed [LHS_W-1:0] lhs, rhs_ext;
    logic             tilted;
    logic             out_load;
    logic [CNT_W-1:0] run_inc;

    function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
        abs16 = v[AXIS_W-1] ? AXIS_W'(~v + 1'b1) : AXIS_W'(v);
    endfunction

    function automatic logic [REF_W-1:0] abs20(input logic signed [REF_W-1:0] v);
        abs20 = v[REF_W-1] ? REF_W'(~v + 1'b1) : REF_W'(v);
    endfunction

    function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(
        input logic [REM_W-1:0]  rem,
        input logic [ROOT_W-1:0] root,
        input logic [1:0]        pair
    );
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] cand;
        trial = {rem, pair};
        cand  = {1'b0, root, 2'b01};
        if (trial >= cand)
        begin
            sqrt_step = {REM_W'(trial - cand), root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            sqrt_step = {REM_W'(trial), root[ROOT_W-2:0], 1'b0};
        end
    endfunction

    assign a_in[0] = sample.accel_x;
    assign a_in[1] = sample.accel_y;
    assign a_in[2] = sample.accel_z;
    assign g_in[0] = sample.gyro_x;
    assign g_in[1] = sample.gyro_y;
    assign g_in[2] = sample.gyro_z;

    assign target = (samples_reg < CNT_W'(MAX_CALIB_SAMPLES)) ? samples_reg
                                                              : CNT_W'(MAX_CALIB_SAMPLES);
    assign calibrating = taken_reg < target;
    assign amag    = root_reg[0][MAG_W-1:0];
    assign am      = (amag == '0) ? MAG_W'(1) : amag;
    assign smag    = (root_reg[2] == '0) ? ROOT_W'(1) : root_reg[2];
    assign lhs     = {dsum_reg[DOT_W-1], dsum_reg, 15'b0};
    assign rhs_ext = {2'b00, rhs_reg};
    assign tilted  = lhs < rhs_ext;
    assign run_inc = (run_reg < 4'd15) ? run_reg + 1'b1 : run_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (sample.valid) state_next = ST_MUL;
            ST_MUL:    if (cnt_reg == STEP_W'(MUL_STEPS - 1)) state_next = ST_SUM;
            ST_SUM:    state_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == STEP_W'(SQRT_STEPS - 1)) state_next = ST_DECIDE;
            ST_DECIDE: state_next = calibrating ? ST_OUT : ST_RHS1;
            ST_RHS1:   if (cnt_reg == STEP_W'(RHS1_STEPS - 1)) state_next = ST_RHS2;
            ST_RHS2:   if (cnt_reg == STEP_W'(RHS2_STEPS - 1)) state_next = ST_CMP;
            ST_CMP:    state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        sample.ready = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: sample.ready = 1'b1;
            ST_OUT:  out_load = !out_valid_reg || result.ready;
            default: ;
        endcase
    end

    assign cfg.ready = 1'b1;

    // config and control state
    always_comb
    begin
        low_next     = low_reg;
        high_next    = high_reg;
        samples_next = samples_reg;
        cos_next     = cos_reg;
        confirm_next = confirm_reg;
        if (cfg.valid)
        begin
            case (tfd_reg_t'(cfg.index))
                REG_MAG_LOW:  low_next     = cfg.data;
                REG_MAG_HIGH: high_next    = cfg.data;
                REG_SAMPLES:  samples_next = cfg.data[CNT_W-1:0];
                REG_COS:      cos_next     = cfg.data;
                REG_CONFIRM:  confirm_next = cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end

        ref_next   = ref_reg;
        taken_next = taken_reg;
        run_next   = run_reg;
        fall_next  = fall_reg;
        if (state_reg == ST_DECIDE && calibrating && amag >= low_reg && amag <= high_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ref_next[i] = ref_reg[i] + REF_W'(acc_reg[i]);
            end
            taken_next = taken_reg + 1'b1;
        end
        if (state_reg == ST_CMP)
        begin
            if (tilted)
            begin
                run_next = run_inc;
                if (run_inc >= confirm_reg) fall_next = 1'b1;
            end
            else
            begin
                run_next  = '0;
                fall_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg && !result.ready;
        amag_out_next  = amag_out_reg;
        gmag_out_next  = gmag_out_reg;
        fall_out_next  = fall_out_reg;
        cal_out_next   = cal_out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            amag_out_next  = amag;
            gmag_out_next  = root_reg[1][MAG_W-1:0];
            fall_out_next  = fall_reg;
            cal_out_next   = !calibrating;
        end
    end

    // serial datapath
    always_comb
    begin
        acc_next  = acc_reg;
        amq_next  = amq_reg;
        gmq_next  = gmq_reg;
        smq_next  = smq_reg;
        amc_next  = amc_reg;
        gmc_next  = gmc_reg;
        smc_next  = smc_reg;
        dmc_next  = dmc_reg;
        asq_next  = asq_reg;
        gsq_next  = gsq_reg;
        ssq_next  = ssq_reg;
        term_next = term_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        dsum_next = dsum_reg;
        p1q_next  = p1q_reg;
        p1mc_next = p1mc_reg;
        p1_next   = p1_reg;
        p2q_next  = p2q_reg;
        p2mc_next = p2mc_reg;
        rhs_next  = rhs_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    acc_next[i]  = a_in[i];
                    amq_next[i]  = abs16(a_in[i]);
                    amc_next[i]  = SQ_W'(abs16(a_in[i]));
                    gmq_next[i]  = abs16(g_in[i]);
                    gmc_next[i]  = SQ_W'(abs16(g_in[i]));
                    smq_next[i]  = abs20(ref_reg[i]);
                    smc_next[i]  = SSQ_W'(abs20(ref_reg[i]));
                    dmc_next[i]  = a_in[i][AXIS_W-1] ? -TERM_W'(ref_reg[i])
                                                     : TERM_W'(ref_reg[i]);
                    asq_next[i]  = '0;
                    gsq_next[i]  = '0;
                    ssq_next[i]  = '0;
                    term_next[i] = '0;
                end
            end
            ST_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (amq_reg[i][0])
                    begin
                        asq_next[i]  = asq_reg[i] + amc_reg[i];
                        term_next[i] = term_reg[i] + dmc_reg[i];
                    end
                    if (gmq_reg[i][0]) gsq_next[i] = gsq_reg[i] + gmc_reg[i];
                    if (smq_reg[i][0]) ssq_next[i] = ssq_reg[i] + smc_reg[i];
                    amq_next[i] = amq_reg[i] >> 1;
                    gmq_next[i] = gmq_reg[i] >> 1;
                    smq_next[i] = smq_reg[i] >> 1;
                    amc_next[i] = amc_reg[i] << 1;
                    gmc_next[i] = gmc_reg[i] << 1;
                    smc_next[i] = smc_reg[i] << 1;
                    dmc_next[i] = dmc_reg[i] <<< 1;
                end
                cnt_next = (cnt_reg == STEP_W'(MUL_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_SUM:
            begin
                rad_next[0] = SSQ_W'(SQ_W'(asq_reg[0] + asq_reg[1] + asq_reg[2]));
                rad_next[1] = SSQ_W'(SQ_W'(gsq_reg[0] + gsq_reg[1] + gsq_reg[2]));
                rad_next[2] = ssq_reg[0] + ssq_reg[1] + ssq_reg[2];
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i]  = '0;
                    root_next[i] = '0;
                end
                dsum_next = DOT_W'(term_reg[0]) + DOT_W'(term_reg[1]) + DOT_W'(term_reg[2]);
                cnt_next  = '0;
            end
            ST_SQRT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    {rem_next[i], root_next[i]} =
                        sqrt_step(rem_reg[i], root_reg[i], rad_reg[i][SSQ_W-1:SSQ_W-2]);
                    rad_next[i] = rad_reg[i] << 2;
                end
                cnt_next = (cnt_reg == STEP_W'(SQRT_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                p1q_next  = cos_reg;
                p1mc_next = P1_W'(am);
                p1_next   = '0;
                cnt_next  = '0;
            end
            ST_RHS1:
            begin
                if (p1q_reg[0]) p1_next = p1_reg + p1mc_reg;
                p1q_next  = p1q_reg >> 1;
                p1mc_next = p1mc_reg << 1;
                p2q_next  = smag;
                p2mc_next = RHS_W'(p1_next);
                rhs_next  = '0;
                cnt_next  = (cnt_reg == STEP_W'(RHS1_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            ST_RHS2:
            begin
                if (p2q_reg[0]) rhs_next = rhs_reg + p2mc_reg;
                p2q_next  = p2q_reg >> 1;
                p2mc_next = p2mc_reg << 1;
                cnt_next  = (cnt_reg == STEP_W'(RHS2_STEPS - 1)) ? '0 : cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            low_reg       <= RST_MAG_LOW;
            high_reg      <= RST_MAG_HIGH;
            samples_reg   <= RST_SAMPLES;
            cos_reg       <= RST_COS;
            confirm_reg   <= RST_CONFIRM;
            for (int i = 0; i < 3; i++)
            begin
                ref_reg[i] <= '0;
            end
            taken_reg     <= '0;
            run_reg       <= '0;
            fall_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            samples_reg   <= samples_next;
            cos_reg       <= cos_next;
            confirm_reg   <= confirm_next;
            ref_reg       <= ref_next;
            taken_reg     <= taken_next;
            run_reg       <= run_next;
            fall_reg      <= fall_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        amq_reg      <= amq_next;
        gmq_reg      <= gmq_next;
        smq_reg      <= smq_next;
        amc_reg      <= amc_next;
        gmc_reg      <= gmc_next;
        smc_reg      <= smc_next;
        dmc_reg      <= dmc_next;
        asq_reg      <= asq_next;
        gsq_reg      <= gsq_next;
        ssq_reg      <= ssq_next;
        term_reg     <= term_next;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        dsum_reg     <= dsum_next;
        p1q_reg      <= p1q_next;
        p1mc_reg     <= p1mc_next;
        p1_reg       <= p1_next;
        p2q_reg      <= p2q_next;
        p2mc_reg     <= p2mc_next;
        rhs_reg      <= rhs_next;
        amag_out_reg <= amag_out_next;
        gmag_out_reg <= gmag_out_next;
        fall_out_reg <= fall_out_next;
        cal_out_reg  <= cal_out_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.accel_magnitude = amag_out_reg;
    assign result.gyro_magnitude  = gmag_out_reg;
    assign result.fall_detected   = fall_out_reg;
    assign result.calibrated      = cal_out_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> state_reg == ST_MUL)
        else $error("accepted sample did not start the multiply phase");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

    a_fall_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        fall_reg |-> run_reg != '0)
        else $error("fall flag set with empty tilt run");

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= CNT_W'(MAX_CALIB_SAMPLES))
        else $error("calibration count beyond limit");

endmodule
